@@ src/slcg_pkg.sv @@
// ----------------------------------------------------------------------------
// slcg_pkg: shared types and constants for the status LED color generator
// Holds the request and result structs, status mode codes and the fixed
// scaling helper used by the color wheel and the pulse logic.
// ----------------------------------------------------------------------------
package slcg_pkg;

  localparam logic [1:0] KIND_BOOT      = 2'd0;
  localparam logic [1:0] KIND_CONNECTED = 2'd1;
  localparam logic [1:0] KIND_SEARCHING = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam int unsigned LEVEL_FULL       = 255;
  localparam int unsigned AMBER_NUM        = 2;
  localparam int unsigned AMBER_DEN        = 5;
  localparam int unsigned AMBER_RECIP      = 205;
  localparam int unsigned AMBER_RECIP_BITS = 10;

  localparam logic [7:0] MAX_BRIGHT_RESET = 8'(LEVEL_FULL);
  localparam logic [7:0] AMBER_RESET      = 8'((LEVEL_FULL * AMBER_NUM) / AMBER_DEN);

  localparam logic [7:0] REGION_WIDTH = 8'd43;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] phase;
    logic [7:0]  hue;
  } slcg_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } slcg_rgb_t;

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

@@ src/slcg_wheel.sv @@
// ----------------------------------------------------------------------------
// slcg_wheel: six-region hue color wheel
// Splits the hue into a region and an offset, scales the rising ramp by
// the peak level and places the ramps on the channels of that region.
// ----------------------------------------------------------------------------
module slcg_wheel (
  input  logic [7:0]          hue,
  input  logic [7:0]          max_bright,
  output slcg_pkg::slcg_rgb_t rgb
);
  import slcg_pkg::*;

  logic [2:0]  region;
  logic [7:0]  base;
  logic [7:0]  offset;
  logic [7:0]  ramp;
  logic [15:0] prod;
  logic [7:0]  up;
  logic [7:0]  down;

  always_comb begin
    priority if (hue >= 8'(5 * REGION_WIDTH)) begin
      region = 3'd5;
      base   = 8'(5 * REGION_WIDTH);
    end else if (hue >= 8'(4 * REGION_WIDTH)) begin
      region = 3'd4;
      base   = 8'(4 * REGION_WIDTH);
    end else if (hue >= 8'(3 * REGION_WIDTH)) begin
      region = 3'd3;
      base   = 8'(3 * REGION_WIDTH);
    end else if (hue >= 8'(2 * REGION_WIDTH)) begin
      region = 3'd2;
      base   = 8'(2 * REGION_WIDTH);
    end else if (hue >= REGION_WIDTH) begin
      region = 3'd1;
      base   = REGION_WIDTH;
    end else begin
      region = 3'd0;
      base   = 8'd0;
    end
  end

  assign offset = hue - base;
  assign ramp   = {offset[5:0], 2'b00} + {offset[6:0], 1'b0};
  assign prod   = {8'd0, max_bright} * {8'd0, ramp};
  assign up     = div255(prod);
  assign down   = max_bright - up;

  always_comb begin
    unique case (region)
      3'd0:    rgb = '{red: max_bright, green: up,         blue: 8'd0};
      3'd1:    rgb = '{red: down,       green: max_bright, blue: 8'd0};
      3'd2:    rgb = '{red: 8'd0,       green: max_bright, blue: up};
      3'd3:    rgb = '{red: 8'd0,       green: down,       blue: max_bright};
      3'd4:    rgb = '{red: up,         green: 8'd0,       blue: max_bright};
      default: rgb = '{red: max_bright, green: 8'd0,       blue: down};
    endcase
  end

endmodule

@@ src/slcg_anim.sv @@
// ----------------------------------------------------------------------------
// slcg_anim: phase-driven animations
// Produces the amber breathing pulse for searching mode and the red blink
// for error mode from the animation phase.
// ----------------------------------------------------------------------------
module slcg_anim (
  input  logic [15:0]         phase,
  input  logic [7:0]          max_bright,
  input  logic [7:0]          amber_green,
  output slcg_pkg::slcg_rgb_t pulse_rgb,
  output slcg_pkg::slcg_rgb_t blink_rgb
);
  import slcg_pkg::*;

  logic [7:0]  tpos;
  logic [7:0]  tri_level;
  logic [15:0] red_prod;
  logic [15:0] green_prod;

  assign tpos      = phase[10:3];
  assign tri_level = tpos[7] ? {~tpos[6:0], 1'b0} : {tpos[6:0], 1'b0};

  assign red_prod   = {8'd0, max_bright} * {8'd0, tri_level};
  assign green_prod = {8'd0, amber_green} * {8'd0, tri_level};

  assign pulse_rgb = '{red: div255(red_prod), green: div255(green_prod), blue: 8'd0};
  assign blink_rgb = '{red: phase[8] ? max_bright : 8'd0, green: 8'd0, blue: 8'd0};

endmodule

@@ src/status_led_color_generator.sv @@
// ----------------------------------------------------------------------------
// status_led_color_generator: status LED color generator
// A request is taken on any cycle with start high; busy is always low, so
// one request per clock is sustained. Each result is held on out_rsp with
// out_valid high for a single cycle, after one input register and one result
// register. It cannot be held off. The peak level is written over the cfg
// channel, which is always ready, and applies to requests taken at or after
// the edge of the write.
// ----------------------------------------------------------------------------
module status_led_color_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  slcg_pkg::slcg_req_t in_req,
  output logic                out_valid,
  output slcg_pkg::slcg_rgb_t out_rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import slcg_pkg::*;

  logic      req_valid_r;
  slcg_req_t req_r;
  logic      out_valid_r;
  slcg_rgb_t out_r;
  slcg_rgb_t out_nxt;
  logic [7:0] max_bright_r;
  logic [7:0] amber_r;
  logic [7:0] amber_nxt;
  logic [17:0] amber_prod;
  slcg_rgb_t wheel_rgb;
  slcg_rgb_t pulse_rgb;
  slcg_rgb_t blink_rgb;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign amber_prod = {9'd0, cfg_data, 1'b0} * 18'(AMBER_RECIP);
  assign amber_nxt  = {1'b0, amber_prod[AMBER_RECIP_BITS +: 7]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bright_r <= MAX_BRIGHT_RESET;
      amber_r      <= AMBER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_bright_r <= cfg_data;
      amber_r      <= amber_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= start && !busy;
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req;
    end
    if (req_valid_r) begin
      out_r <= out_nxt;
    end
  end

  slcg_wheel u_wheel (
    .hue        (req_r.hue),
    .max_bright (max_bright_r),
    .rgb        (wheel_rgb)
  );

  slcg_anim u_anim (
    .phase       (req_r.phase),
    .max_bright  (max_bright_r),
    .amber_green (amber_r),
    .pulse_rgb   (pulse_rgb),
    .blink_rgb   (blink_rgb)
  );

  always_comb begin
    unique case (req_r.kind)
      KIND_CONNECTED: out_nxt = wheel_rgb;
      KIND_SEARCHING: out_nxt = pulse_rgb;
      KIND_ERROR:     out_nxt = blink_rgb;
      default:        out_nxt = '0;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result without a request two cycles earlier");

  a_boot_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start, 2) && ($past(in_req.kind, 2) == KIND_BOOT) |-> out_rsp == '0)
    else $error("boot mode request gave a lit LED");

  a_error_red_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_req.kind, 2) == KIND_ERROR) |->
      out_rsp.green == 8'd0 && out_rsp.blue == 8'd0 &&
      ($past(in_req.phase[8], 2) || out_rsp.red == 8'd0))
    else $error("error mode result is not a plain red blink");

endmodule
